[rtl/assert_macros.svh]
// assertion macros for the rtl files that check themselves
// each macro samples on the rising edge of clock and is disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every active edge
`define ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/mmiq_pkg.sv]
// shared constants, status codes and control structs of the min-max quantizer
// no dependencies; used by the other rtl files, except assert_macros.svh, through scoped names
package mmiq_pkg;

   localparam int DEPTH     = 64;
   localparam int LEVEL_MAX = 65535;

   localparam int SAMPLE_W    = 32;
   localparam int STORE_W     = SAMPLE_W + 1;
   localparam int OUT_LEVEL_W = 16;
   localparam int STATUS_W    = 2;
   localparam int BAD_W       = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int LEVEL_W = $clog2(LEVEL_MAX + 1);
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);

   localparam logic [SAMPLE_W-1:0] BIAS = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HIGH   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_NORMAL    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_VALID  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FLAT      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic req_take;
      logic summarize;
      logic rd_en;
      logic div_start;
      logic load_out;
   } mmiq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic closing;
      logic div_done;
      logic last_item;
      logic out_free;
   } mmiq_stat_type;

endpackage

[rtl/mmiq_stream_if.sv]
// valid/ready channel interfaces for the request and result streams
// depends on mmiq_pkg for field widths
interface mmiq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mmiq_pkg::SAMPLE_W-1:0]  sample;
   logic                                  sample_ok;
   logic                                  set_end;

   modport source (output valid, sample, sample_ok, set_end, input ready);
   modport sink   (input valid, sample, sample_ok, set_end, output ready);
endinterface

interface mmiq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic        [mmiq_pkg::OUT_LEVEL_W-1:0] level;
   logic        [mmiq_pkg::STATUS_W-1:0]    status;
   logic        [mmiq_pkg::BAD_W-1:0]       bad_count;
   logic signed [mmiq_pkg::SAMPLE_W-1:0]    seen_low;
   logic signed [mmiq_pkg::SAMPLE_W-1:0]    seen_high;
   logic signed [mmiq_pkg::SAMPLE_W-1:0]    report_low;
   logic signed [mmiq_pkg::SAMPLE_W-1:0]    report_high;
   logic                                   final_item;

   modport source (output valid, level, status, bad_count, seen_low, seen_high,
                   report_low, report_high, final_item, input ready);
   modport sink   (input valid, level, status, bad_count, seen_low, seen_high,
                   report_low, report_high, final_item, output ready);
endinterface

[rtl/mmiq_divider.sv]
// serial scaler: (2*(v-low)*LEVEL_MAX + span) / (2*span), one quotient bit a cycle
// depends on mmiq_pkg
module mmiq_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mmiq_pkg::SAMPLE_W-1:0]  value_b,
   input  logic [mmiq_pkg::SAMPLE_W-1:0]  low_b,
   input  logic [mmiq_pkg::SAMPLE_W-1:0]  span,
   output logic                           done,
   output logic [mmiq_pkg::LEVEL_W-1:0]   quotient
);

   localparam int PROD_W = mmiq_pkg::SAMPLE_W + mmiq_pkg::LEVEL_W;
   localparam int NUM_W  = PROD_W + 2;
   localparam int REM_W  = NUM_W - mmiq_pkg::LEVEL_W;
   localparam int STEP_W = $clog2(mmiq_pkg::LEVEL_W);
   localparam int LW     = mmiq_pkg::LEVEL_W;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_LOAD = 2'd2;
   localparam logic [1:0] PH_STEP = 2'd3;

   logic [1:0]                      phase_ff, phase_in;
   logic                            done_ff, done_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic [mmiq_pkg::SAMPLE_W-1:0]   d_ff, d_in;
   logic [mmiq_pkg::SAMPLE_W-1:0]   span_ff, span_in;
   logic [PROD_W-1:0]               prod_ff, prod_in;
   logic [REM_W-1:0]                rem_ff, rem_in;
   logic [LW-1:0]                   quo_ff, quo_in;
   logic [mmiq_pkg::SAMPLE_W:0]     dvs_ff, dvs_in;

   logic [NUM_W-1:0] num;
   logic [REM_W-1:0] trial;
   logic             fits;

   assign num   = {prod_ff, 1'b0} + NUM_W'(span_ff);
   assign trial = {rem_ff[REM_W-2:0], quo_ff[LW-1]};
   assign fits  = trial >= REM_W'(dvs_ff);

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      d_in     = d_ff;
      span_in  = span_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               d_in     = value_b - low_b;
               span_in  = span;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            prod_in  = PROD_W'(d_ff) * PROD_W'(mmiq_pkg::LEVEL_MAX);
            phase_in = PH_LOAD;
         end
         PH_LOAD: begin
            rem_in   = num[NUM_W-1 -: REM_W];
            quo_in   = num[LW-1:0];
            dvs_in   = {span_ff, 1'b0};
            step_in  = STEP_W'(LW - 1);
            phase_in = PH_STEP;
         end
         PH_STEP: begin
            rem_in = fits ? (trial - REM_W'(dvs_ff)) : trial;
            quo_in = {quo_ff[LW-2:0], fits};
            if (step_ff == '0) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      d_ff    <= d_in;
      span_ff <= span_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/mmiq_datapath.sv]
// datapath: sample store, range trackers, set summary, divider and result register
// depends on mmiq_pkg and mmiq_divider
module mmiq_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  mmiq_pkg::mmiq_cmd_type             cmd,
   output mmiq_pkg::mmiq_stat_type            stat,
   input  logic [mmiq_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                               req_sample_ok,
   input  logic                               req_set_end,
   input  logic                               csr_wr_en,
   input  logic [mmiq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mmiq_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [mmiq_pkg::OUT_LEVEL_W-1:0]   rsp_level,
   output logic [mmiq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mmiq_pkg::BAD_W-1:0]         rsp_bad_count,
   output logic [mmiq_pkg::SAMPLE_W-1:0]      rsp_seen_low,
   output logic [mmiq_pkg::SAMPLE_W-1:0]      rsp_seen_high,
   output logic [mmiq_pkg::SAMPLE_W-1:0]      rsp_report_low,
   output logic [mmiq_pkg::SAMPLE_W-1:0]      rsp_report_high,
   output logic                               rsp_final_item
);

   localparam int SW = mmiq_pkg::SAMPLE_W;
   localparam int CW = mmiq_pkg::CNT_W;
   localparam int AW = mmiq_pkg::ADDR_W;

   // configuration registers
   logic          range_en_ff;
   logic [SW-1:0] src_low_ff;
   logic [SW-1:0] src_high_ff;

   // sample store
   logic [mmiq_pkg::STORE_W-1:0] store_ff [mmiq_pkg::DEPTH];
   logic [mmiq_pkg::STORE_W-1:0] rd_data_ff;

   // running set state, min and max kept biased so unsigned compares order them
   logic [SW-1:0] run_low_ff, run_low_in;
   logic [SW-1:0] run_high_ff, run_high_in;
   logic [CW-1:0] tally_ff, tally_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          any_ff, any_in;

   // summary of the closed set
   logic [mmiq_pkg::STATUS_W-1:0] sum_status_ff;
   logic [CW-1:0]                 sum_bad_ff;
   logic [SW-1:0]                 seen_low_ff, seen_high_ff;
   logic [SW-1:0]                 rep_low_ff, rep_high_ff;
   logic [SW-1:0]                 low_b_ff, span_ff;
   logic [CW-1:0]                 count_ff;
   logic [AW-1:0]                 k_ff, k_in;

   // result register
   logic                             out_valid_ff, out_valid_in;
   logic [mmiq_pkg::OUT_LEVEL_W-1:0] out_level_ff;
   logic [mmiq_pkg::STATUS_W-1:0]    out_status_ff;
   logic [mmiq_pkg::BAD_W-1:0]       out_bad_ff;
   logic [SW-1:0]                    out_seen_low_ff, out_seen_high_ff;
   logic [SW-1:0]                    out_rep_low_ff, out_rep_high_ff;
   logic                             out_final_ff;

   logic [SW-1:0]                    sample_b;
   logic                             bad_range;
   logic [mmiq_pkg::STATUS_W-1:0]    status_new;
   logic                             div_done;
   logic [mmiq_pkg::LEVEL_W-1:0]     div_q;
   logic [mmiq_pkg::OUT_LEVEL_W-1:0] level_new;

   assign sample_b  = req_sample ^ mmiq_pkg::BIAS;
   assign bad_range = range_en_ff &&
                      ((src_low_ff ^ mmiq_pkg::BIAS) > (src_high_ff ^ mmiq_pkg::BIAS));

   always_comb begin
      if (bad_range) begin
         status_new = mmiq_pkg::ST_BAD_RANGE;
      end else if (!any_ff) begin
         status_new = mmiq_pkg::ST_NO_VALID;
      end else if (run_low_ff == run_high_ff) begin
         status_new = mmiq_pkg::ST_FLAT;
      end else begin
         status_new = mmiq_pkg::ST_NORMAL;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         range_en_ff <= 1'b0;
         src_low_ff  <= '0;
         src_high_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mmiq_pkg::CSR_SRC_ENABLE: range_en_ff <= csr_wdata[0];
            mmiq_pkg::CSR_SRC_LOW:    src_low_ff  <= csr_wdata[SW-1:0];
            mmiq_pkg::CSR_SRC_HIGH:   src_high_ff <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // store: one write port at the fill index, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         store_ff[fill_ff[AW-1:0]] <= {req_sample_ok, req_sample};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_ff[k_ff];
      end
   end

   always_comb begin
      run_low_in  = run_low_ff;
      run_high_in = run_high_ff;
      tally_in    = tally_ff;
      fill_in     = fill_ff;
      any_in      = any_ff;
      if (cmd.summarize) begin
         run_low_in  = '1;
         run_high_in = '0;
         tally_in    = '0;
         fill_in     = '0;
         any_in      = 1'b0;
      end else if (cmd.req_take) begin
         fill_in = fill_ff + CW'(1);
         if (req_sample_ok) begin
            any_in = 1'b1;
            if (sample_b < run_low_ff) begin
               run_low_in = sample_b;
            end
            if (sample_b > run_high_ff) begin
               run_high_in = sample_b;
            end
         end else begin
            tally_in = tally_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_low_ff  <= '1;
         run_high_ff <= '0;
         tally_ff    <= '0;
         fill_ff     <= '0;
         any_ff      <= 1'b0;
      end else begin
         run_low_ff  <= run_low_in;
         run_high_ff <= run_high_in;
         tally_ff    <= tally_in;
         fill_ff     <= fill_in;
         any_ff      <= any_in;
      end
   end

   // set summary, taken once when the set closes
   always_ff @(posedge clock) begin
      if (cmd.summarize) begin
         sum_status_ff <= status_new;
         sum_bad_ff    <= tally_ff;
         seen_low_ff   <= any_ff ? (run_low_ff ^ mmiq_pkg::BIAS) : '0;
         seen_high_ff  <= any_ff ? (run_high_ff ^ mmiq_pkg::BIAS) : '0;
         rep_low_ff    <= range_en_ff ? src_low_ff
                          : (any_ff ? (run_low_ff ^ mmiq_pkg::BIAS) : '0);
         rep_high_ff   <= range_en_ff ? src_high_ff
                          : (any_ff ? (run_high_ff ^ mmiq_pkg::BIAS) : '0);
         low_b_ff      <= run_low_ff;
         span_ff       <= run_high_ff - run_low_ff;
         count_ff      <= fill_ff;
      end
   end

   always_comb begin
      k_in = k_ff;
      if (cmd.summarize) begin
         k_in = '0;
      end else if (cmd.load_out && !stat.last_item) begin
         k_in = k_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   mmiq_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .value_b  (rd_data_ff[SW-1:0] ^ mmiq_pkg::BIAS),
      .low_b    (low_b_ff),
      .span     (span_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // invalid samples and abnormal sets give level zero
   assign level_new = (sum_status_ff == mmiq_pkg::ST_NORMAL && rd_data_ff[SW])
                      ? mmiq_pkg::OUT_LEVEL_W'(div_q) : '0;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (cmd.load_out) begin
         out_level_ff     <= level_new;
         out_status_ff    <= sum_status_ff;
         out_bad_ff       <= mmiq_pkg::BAD_W'(sum_bad_ff);
         out_seen_low_ff  <= seen_low_ff;
         out_seen_high_ff <= seen_high_ff;
         out_rep_low_ff   <= rep_low_ff;
         out_rep_high_ff  <= rep_high_ff;
         out_final_ff     <= stat.last_item;
      end
   end

   assign stat.closing   = req_set_end || (fill_ff == CW'(mmiq_pkg::DEPTH - 1));
   assign stat.div_done  = div_done;
   assign stat.last_item = (CW'(k_ff) + CW'(1)) == count_ff;
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_level       = out_level_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_bad_count   = out_bad_ff;
   assign rsp_seen_low    = out_seen_low_ff;
   assign rsp_seen_high   = out_seen_high_ff;
   assign rsp_report_low  = out_rep_low_ff;
   assign rsp_report_high = out_rep_high_ff;
   assign rsp_final_item  = out_final_ff;

endmodule

[rtl/mmiq_ctrl.sv]
// controller: collects a set, then sequences read, divide and hand-off per sample
// depends on mmiq_pkg
module mmiq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mmiq_pkg::mmiq_stat_type  stat,
   output mmiq_pkg::mmiq_cmd_type   cmd
);

   localparam logic [2:0] S_COLLECT = 3'd0;
   localparam logic [2:0] S_SUMMARY = 3'd1;
   localparam logic [2:0] S_READ    = 3'd2;
   localparam logic [2:0] S_START   = 3'd3;
   localparam logic [2:0] S_WAIT    = 3'd4;
   localparam logic [2:0] S_PUT     = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_COLLECT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_COLLECT: begin
            cmd.req_take = req_valid;
            if (req_valid && stat.closing) begin
               state_in = S_SUMMARY;
            end
         end
         S_SUMMARY: begin
            cmd.summarize = 1'b1;
            state_in      = S_READ;
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_START;
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (stat.div_done) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = stat.last_item ? S_COLLECT : S_READ;
            end
         end
         default: state_in = S_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/minmax_intensity_quantizer.sv]
// top level of the min-max intensity quantizer: controller plus datapath
// depends on mmiq_pkg, mmiq_stream_if, mmiq_ctrl, mmiq_datapath and assert_macros.svh
//
//  channel  dir  handshake     carries
//  req_ch   in   valid/ready   sample, sample_ok, set_end
//  rsp_ch   out  valid/ready   level, status, bad_count, seen/report range, final_item
//  csr_*    in   csr_wr_en     csr_index, csr_wdata (no wait, no read-back)
//
// loading takes one request per cycle into the sample store while collecting
// a closing request is followed by a summary step, then each result is made by a
// read, a subtract, a 32x16 multiply, a load step and the one-bit-a-cycle divider;
// no request is taken until the set is emitted
// the next result is computed while the previous one waits in the result register
// reset is synchronous and clears control, range trackers and configuration; the
// sample store is not cleared since only entries of the current set are read
`include "assert_macros.svh"

module minmax_intensity_quantizer (
   input  logic                                clock,
   input  logic                                reset,
   mmiq_req_if.sink                            req_ch,
   mmiq_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [mmiq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mmiq_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // command and status between the two halves
   mmiq_pkg::mmiq_cmd_type  cmd;
   mmiq_pkg::mmiq_stat_type stat;

   logic                             req_ready;
   logic                             rsp_valid;
   logic [mmiq_pkg::OUT_LEVEL_W-1:0] rsp_level;
   logic [mmiq_pkg::STATUS_W-1:0]    rsp_status;
   logic [mmiq_pkg::BAD_W-1:0]       rsp_bad_count;
   logic [mmiq_pkg::SAMPLE_W-1:0]    rsp_seen_low;
   logic [mmiq_pkg::SAMPLE_W-1:0]    rsp_seen_high;
   logic [mmiq_pkg::SAMPLE_W-1:0]    rsp_report_low;
   logic [mmiq_pkg::SAMPLE_W-1:0]    rsp_report_high;
   logic                             rsp_final_item;

   // sequencer: collect, summarize, then one read-divide-put loop per sample
   mmiq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, trackers, divider and result register
   mmiq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_sample      (req_ch.sample),
      .req_sample_ok   (req_ch.sample_ok),
      .req_set_end     (req_ch.set_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_valid),
      .rsp_level       (rsp_level),
      .rsp_status      (rsp_status),
      .rsp_bad_count   (rsp_bad_count),
      .rsp_seen_low    (rsp_seen_low),
      .rsp_seen_high   (rsp_seen_high),
      .rsp_report_low  (rsp_report_low),
      .rsp_report_high (rsp_report_high),
      .rsp_final_item  (rsp_final_item)
   );

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.level       = rsp_level;
   assign rsp_ch.status      = rsp_status;
   assign rsp_ch.bad_count   = rsp_bad_count;
   assign rsp_ch.seen_low    = $signed(rsp_seen_low);
   assign rsp_ch.seen_high   = $signed(rsp_seen_high);
   assign rsp_ch.report_low  = $signed(rsp_report_low);
   assign rsp_ch.report_high = $signed(rsp_report_high);
   assign rsp_ch.final_item  = rsp_final_item;

   // a pending result is never overwritten
   `ASSERT_SAME(a_no_overwrite, cmd.load_out, stat.out_free)
   // divider completion is a single-cycle pulse
   `ASSERT_NEXT(a_done_pulse, stat.div_done, !stat.div_done)
   // collecting and emitting never overlap
   `ASSERT_ALWAYS(a_take_vs_put, !(cmd.req_take && (cmd.load_out || cmd.div_start)))
   // only a normal set carries nonzero levels
   `ASSERT_SAME(a_level_zero, rsp_valid && rsp_status != mmiq_pkg::ST_NORMAL, rsp_level == '0)

endmodule

[dv/minmax_intensity_quantizer_test.sv]
// self-checking testbench for the min-max intensity quantizer
// depends on mmiq_pkg, mmiq_stream_if and the minmax_intensity_quantizer rtl
// directed table first, then random sample sets checked against a local model
module minmax_intensity_quantizer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 11;
   // drain margin that covers the summary state and the results of the serial divider
   localparam int SETTLE_CYCLES = 2 * (mmiq_pkg::LEVEL_W + 6) + 4;
   localparam int LONG_STALL    = 600;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 25;

   localparam logic signed [mmiq_pkg::SAMPLE_W-1:0] MOST_NEG =
      {1'b1, {(mmiq_pkg::SAMPLE_W-1){1'b0}}};
   localparam logic signed [mmiq_pkg::SAMPLE_W-1:0] MOST_POS =
      {1'b0, {(mmiq_pkg::SAMPLE_W-1){1'b1}}};

   // source range settings used by the table and the random phases
   typedef enum logic [2:0] {
      RANGE_KEEP,
      RANGE_RESET,
      RANGE_INVERTED,
      RANGE_FULL,
      RANGE_SWAPPED,
      RANGE_MASKED
   } range_choice_type;

   typedef struct packed {
      range_choice_type                     range;
      logic signed [mmiq_pkg::SAMPLE_W-1:0] sample;
      logic                                 ok;
      logic                                 last;
      logic                                 typed;
      logic [mmiq_pkg::OUT_LEVEL_W-1:0]     level;
      logic [mmiq_pkg::STATUS_W-1:0]        status;
   } stimulus_row_type;

   typedef struct packed {
      logic [mmiq_pkg::OUT_LEVEL_W-1:0]     level;
      logic [mmiq_pkg::STATUS_W-1:0]        status;
      logic [mmiq_pkg::BAD_W-1:0]           bad_count;
      logic signed [mmiq_pkg::SAMPLE_W-1:0] seen_low;
      logic signed [mmiq_pkg::SAMPLE_W-1:0] seen_high;
      logic signed [mmiq_pkg::SAMPLE_W-1:0] report_low;
      logic signed [mmiq_pkg::SAMPLE_W-1:0] report_high;
      logic                                 final_item;
   } level_result_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [mmiq_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mmiq_pkg::CSR_DATA_W-1:0] csr_wdata;

   mmiq_req_if req_ch ();
   mmiq_rsp_if rsp_ch ();

   minmax_intensity_quantizer uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------
   // local model of the quantizer: sample store, range trackers,
   // invalid tally and a copy of the source range registers
   // ---------------------------------------------------------------
   logic signed [mmiq_pkg::SAMPLE_W-1:0] held_sample [mmiq_pkg::DEPTH];
   logic                                 held_ok     [mmiq_pkg::DEPTH];
   logic signed [mmiq_pkg::SAMPLE_W-1:0] track_low;
   logic signed [mmiq_pkg::SAMPLE_W-1:0] track_high;
   logic [mmiq_pkg::BAD_W-1:0]           bad_tally;
   int unsigned                          held_count;
   logic                                 have_valid;

   logic                                 range_en;
   logic signed [mmiq_pkg::SAMPLE_W-1:0] range_low;
   logic signed [mmiq_pkg::SAMPLE_W-1:0] range_high;

   // level and status typed into the table, pinned to a slot of the open set
   logic                             pin_valid  [mmiq_pkg::DEPTH];
   logic [mmiq_pkg::OUT_LEVEL_W-1:0] pin_level  [mmiq_pkg::DEPTH];
   logic [mmiq_pkg::STATUS_W-1:0]    pin_status [mmiq_pkg::DEPTH];

   level_result_type  expected_levels [$];
   stimulus_row_type  directed_rows [$];

   int unsigned failures = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_token = 0;
   int unsigned cycle_count = 0;

   task automatic clear_tracking();
      track_low  = MOST_POS;
      track_high = MOST_NEG;
      bad_tally  = '0;
      held_count = 0;
      have_valid = 1'b0;
   endtask

   // take one accepted request into the model; a closing request
   // queues one expected result per held sample
   task automatic quantize_sample(input logic signed [mmiq_pkg::SAMPLE_W-1:0] smp,
                                  input logic ok, input logic last);
      int unsigned                          slot;
      logic [mmiq_pkg::STATUS_W-1:0]        st;
      logic signed [mmiq_pkg::SAMPLE_W-1:0] lo_seen;
      logic signed [mmiq_pkg::SAMPLE_W-1:0] hi_seen;
      longint                               span;
      longint                               offset;
      level_result_type                     r;

      slot = (held_count >= mmiq_pkg::DEPTH) ? mmiq_pkg::DEPTH - 1 : held_count;
      held_sample[slot] = smp;
      held_ok[slot]     = ok;
      held_count        = slot + 1;
      if (ok) begin
         if (smp < track_low) track_low = smp;
         if (smp > track_high) track_high = smp;
         have_valid = 1'b1;
      end else begin
         bad_tally = bad_tally + 1'b1;
      end

      // set still open and store not yet full
      if (!last && held_count < mmiq_pkg::DEPTH) return;

      lo_seen = have_valid ? track_low : '0;
      hi_seen = have_valid ? track_high : '0;
      span    = 0;

      // a bad caller range wins over every other status
      if (range_en && range_low > range_high) st = mmiq_pkg::ST_BAD_RANGE;
      else if (!have_valid) st = mmiq_pkg::ST_NO_VALID;
      else if (track_low == track_high) st = mmiq_pkg::ST_FLAT;
      else begin
         st   = mmiq_pkg::ST_NORMAL;
         span = longint'(track_high) - longint'(track_low);
      end

      for (int k = 0; k < held_count; k++) begin
         r.level = '0;
         if (st == mmiq_pkg::ST_NORMAL && held_ok[k]) begin
            offset  = longint'(held_sample[k]) - longint'(track_low);
            // round half up by exact integer division
            r.level = mmiq_pkg::OUT_LEVEL_W'((2 * offset * mmiq_pkg::LEVEL_MAX + span)
                                            / (2 * span));
         end
         r.status      = st;
         r.bad_count   = bad_tally;
         r.seen_low    = lo_seen;
         r.seen_high   = hi_seen;
         r.report_low  = range_en ? range_low : lo_seen;
         r.report_high = range_en ? range_high : hi_seen;
         r.final_item  = (k + 1 == held_count);
         if (pin_valid[k]) begin
            r.level      = pin_level[k];
            r.status     = pin_status[k];
            pin_valid[k] = 1'b0;
         end
         expected_levels.push_back(r);
      end
      clear_tracking();
   endtask

   // ---------------------------------------------------------------
   // request side: random gaps before each request, valid held until
   // the block takes it, model updated at the accepting edge
   // ---------------------------------------------------------------
   task automatic send_request(input logic signed [mmiq_pkg::SAMPLE_W-1:0] smp,
                               input logic ok, input logic last);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.sample    <= smp;
      req_ch.sample_ok <= ok;
      req_ch.set_end   <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      quantize_sample(smp, ok, last);
   endtask

   // registers change only with the block drained and settled
   task automatic apply_source_range(input logic en,
                                     input logic signed [mmiq_pkg::SAMPLE_W-1:0] lo,
                                     input logic signed [mmiq_pkg::SAMPLE_W-1:0] hi);
      req_ch.valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= mmiq_pkg::CSR_SRC_ENABLE;
      csr_wdata <= mmiq_pkg::CSR_DATA_W'(en);
      @(posedge clock);
      csr_index <= mmiq_pkg::CSR_SRC_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= mmiq_pkg::CSR_SRC_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      range_en   = en;
      range_low  = lo;
      range_high = hi;
   endtask

   task automatic apply_range_choice(input range_choice_type choice);
      case (choice)
         RANGE_RESET:    apply_source_range(1'b0, '0, '0);
         RANGE_INVERTED: apply_source_range(1'b1, 32'sd1, 32'sd0);
         RANGE_FULL:     apply_source_range(1'b1, MOST_NEG, MOST_POS);
         RANGE_SWAPPED:  apply_source_range(1'b1, MOST_POS, MOST_NEG);
         RANGE_MASKED:   apply_source_range(1'b0, MOST_NEG, MOST_POS);
         default: begin
         end
      endcase
   endtask

   task automatic add_row(input range_choice_type choice,
                          input logic signed [mmiq_pkg::SAMPLE_W-1:0] smp,
                          input logic ok, input logic last, input logic typed,
                          input logic [mmiq_pkg::OUT_LEVEL_W-1:0] lvl,
                          input logic [mmiq_pkg::STATUS_W-1:0] st);
      stimulus_row_type row;
      row.range  = choice;
      row.sample = smp;
      row.ok     = ok;
      row.last   = last;
      row.typed  = typed;
      row.level  = lvl;
      row.status = st;
      directed_rows.push_back(row);
   endtask

   // random sample sets; every phase ends on a closed set
   task automatic run_random_phase(input int n_items, input bit want_full);
      int                                   sent;
      int                                   len;
      int                                   flavor;
      int                                   bad_pct;
      int                                   pick;
      logic signed [mmiq_pkg::SAMPLE_W-1:0] base;
      logic signed [mmiq_pkg::SAMPLE_W-1:0] smp;
      logic                                 last;

      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99, 0);
         if (want_full) len = mmiq_pkg::DEPTH;
         else if (pick < 65) len = $urandom_range(6, 1);
         else if (pick < 85) len = $urandom_range(30, 7);
         else if (pick < 93) len = $urandom_range(mmiq_pkg::DEPTH - 1, 31);
         else if (pick < 97) len = mmiq_pkg::DEPTH;
         // overlong: store fills and closes, the rest opens the next set
         else len = $urandom_range(mmiq_pkg::DEPTH + 16, mmiq_pkg::DEPTH + 1);
         want_full = 1'b0;

         flavor = $urandom_range(3, 0);
         base   = $urandom;
         pick   = $urandom_range(9, 0);
         bad_pct = (pick == 0) ? 100 : (pick < 4) ? 0 : 15;

         for (int k = 0; k < len; k++) begin
            case (flavor)
               0:       smp = $urandom;
               1:       smp = base + $urandom_range(4095, 0);
               2:       smp = base;
               default: smp = base + $urandom_range(2, 0);
            endcase
            // a full store closes by itself, with or without the end flag
            if (len == mmiq_pkg::DEPTH && k == len - 1) last = $urandom_range(1, 0);
            else last = (k == len - 1);
            send_request(smp, $urandom_range(99, 0) >= bad_pct, last);
         end
         sent += len;
      end
   endtask

   // ---------------------------------------------------------------
   // result side: random ready, one long hold-off on request, and the
   // field by field compare against the oldest expectation
   // ---------------------------------------------------------------
   initial begin : result_sink
      int unsigned      hold_seen;
      int unsigned      stall_left;
      level_result_type got;
      level_result_type want;

      hold_seen    = 0;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.level       = rsp_ch.level;
            got.status      = rsp_ch.status;
            got.bad_count   = rsp_ch.bad_count;
            got.seen_low    = rsp_ch.seen_low;
            got.seen_high   = rsp_ch.seen_high;
            got.report_low  = rsp_ch.report_low;
            got.report_high = rsp_ch.report_high;
            got.final_item  = rsp_ch.final_item;
            if (expected_levels.size() == 0) begin
               $error("result with no request pending: level %0d", got.level);
               failures++;
            end else begin
               want = expected_levels.pop_front();
               if (got.level !== want.level) begin
                  $error("level: expected %0d, got %0d", want.level, got.level);
                  failures++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  failures++;
               end
               if (got.bad_count !== want.bad_count) begin
                  $error("bad_count: expected %0d, got %0d", want.bad_count, got.bad_count);
                  failures++;
               end
               if (got.seen_low !== want.seen_low) begin
                  $error("seen_low: expected %0d, got %0d", want.seen_low, got.seen_low);
                  failures++;
               end
               if (got.seen_high !== want.seen_high) begin
                  $error("seen_high: expected %0d, got %0d", want.seen_high, got.seen_high);
                  failures++;
               end
               if (got.report_low !== want.report_low) begin
                  $error("report_low: expected %0d, got %0d", want.report_low,
                         got.report_low);
                  failures++;
               end
               if (got.report_high !== want.report_high) begin
                  $error("report_high: expected %0d, got %0d", want.report_high,
                         got.report_high);
                  failures++;
               end
               if (got.final_item !== want.final_item) begin
                  $error("final_item: expected %0d, got %0d", want.final_item,
                         got.final_item);
                  failures++;
               end
            end
         end
         // a new token from the stimulus starts a long hold-off
         if (hold_token != hold_seen) begin
            hold_seen  = hold_token;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // run limit, far above the slowest legal run
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      logic signed [mmiq_pkg::SAMPLE_W-1:0] lo;
      logic signed [mmiq_pkg::SAMPLE_W-1:0] hi;
      stimulus_row_type                     row;

      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = mmiq_pkg::CSR_SRC_ENABLE;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.sample    = '0;
      req_ch.sample_ok = 1'b0;
      req_ch.set_end   = 1'b0;
      clear_tracking();
      range_en   = 1'b0;
      range_low  = '0;
      range_high = '0;
      for (int k = 0; k < mmiq_pkg::DEPTH; k++) pin_valid[k] = 1'b0;

      // single sample right after reset: flat range under reset registers
      add_row(RANGE_KEEP, 32'sd100, 1'b1, 1'b1, 1'b1, '0, mmiq_pkg::ST_FLAT);
      // field extremes and an invalid sample in one set
      add_row(RANGE_KEEP, MOST_NEG, 1'b1, 1'b0, 1'b1, '0, mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, MOST_POS, 1'b1, 1'b0, 1'b1, 16'(mmiq_pkg::LEVEL_MAX),
              mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, 32'sd0, 1'b1, 1'b0, 1'b0, '0, mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, 32'sh55555555, 1'b0, 1'b0, 1'b1, '0, mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, -32'sd1, 1'b1, 1'b1, 1'b0, '0, mmiq_pkg::ST_NORMAL);
      // no valid sample at all
      add_row(RANGE_KEEP, 32'shAAAAAAAA, 1'b0, 1'b0, 1'b1, '0, mmiq_pkg::ST_NO_VALID);
      add_row(RANGE_KEEP, 32'sd7, 1'b0, 1'b1, 1'b1, '0, mmiq_pkg::ST_NO_VALID);
      // exact half rounds up
      add_row(RANGE_KEEP, 32'sd0, 1'b1, 1'b0, 1'b0, '0, mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, 32'sd2, 1'b1, 1'b0, 1'b0, '0, mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, 32'sd1, 1'b1, 1'b1, 1'b0, '0, mmiq_pkg::ST_NORMAL);
      // negative samples
      add_row(RANGE_KEEP, -32'sd7, 1'b1, 1'b0, 1'b0, '0, mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, -32'sd3, 1'b1, 1'b0, 1'b0, '0, mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, -32'sd5, 1'b1, 1'b0, 1'b0, '0, mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, -32'sd4, 1'b1, 1'b1, 1'b0, '0, mmiq_pkg::ST_NORMAL);
      // equal valid samples beside an invalid one
      add_row(RANGE_KEEP, -32'sd20, 1'b0, 1'b0, 1'b1, '0, mmiq_pkg::ST_FLAT);
      add_row(RANGE_KEEP, -32'sd20, 1'b1, 1'b0, 1'b1, '0, mmiq_pkg::ST_FLAT);
      add_row(RANGE_KEEP, -32'sd20, 1'b1, 1'b1, 1'b1, '0, mmiq_pkg::ST_FLAT);
      // enabled source range with low above high
      add_row(RANGE_INVERTED, 32'sd10, 1'b1, 1'b0, 1'b1, '0, mmiq_pkg::ST_BAD_RANGE);
      add_row(RANGE_KEEP, 32'sd20, 1'b1, 1'b1, 1'b1, '0, mmiq_pkg::ST_BAD_RANGE);
      add_row(RANGE_SWAPPED, 32'sd5, 1'b0, 1'b1, 1'b1, '0, mmiq_pkg::ST_BAD_RANGE);
      // widest legal source range only shows up in the report fields
      add_row(RANGE_FULL, 32'sd3, 1'b1, 1'b0, 1'b1, '0, mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, 32'sd9, 1'b1, 1'b1, 1'b1, 16'(mmiq_pkg::LEVEL_MAX),
              mmiq_pkg::ST_NORMAL);
      // range written but disabled
      add_row(RANGE_MASKED, -32'sd1, 1'b1, 1'b0, 1'b0, '0, mmiq_pkg::ST_NORMAL);
      add_row(RANGE_KEEP, 32'sd1, 1'b1, 1'b1, 1'b0, '0, mmiq_pkg::ST_NORMAL);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      recv_idle_pct <= 79;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.range != RANGE_KEEP) apply_range_choice(row.range);
         if (row.typed) begin
            pin_valid[held_count]  = 1'b1;
            pin_level[held_count]  = row.level;
            pin_status[held_count] = row.status;
         end
         send_request(row.sample, row.ok, row.last);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_range_choice(RANGE_RESET);
            1: begin
               // random ordered range
               lo = $urandom;
               hi = $urandom;
               if (lo > hi) apply_source_range(1'b1, hi, lo);
               else apply_source_range(1'b1, lo, hi);
            end
            2: apply_range_choice(RANGE_SWAPPED);
            3: apply_range_choice(RANGE_FULL);
            4: begin
               // anything goes, low above high included
               lo = $urandom;
               hi = $urandom;
               apply_source_range(1'b1, lo, hi);
            end
            default: apply_range_choice(RANGE_MASKED);
         endcase

         // receiver sparse first, then sender sparse, then both at full rate
         case (p / 2)
            0: begin
               send_idle_pct = 13;
               recv_idle_pct <= 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct <= 13;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase

         // long result hold-off while requests keep coming
         if (p == 1) hold_token <= hold_token + 1;

         run_random_phase(PHASE_ITEMS, p == 0);
      end

      req_ch.valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
